@@ hdl/symbol_floor_lookup_macros.svh @@
// Assertion macros for the symbol floor lookup block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef SYMBOL_FLOOR_LOOKUP_MACROS_SVH
`define SYMBOL_FLOOR_LOOKUP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/sfl_pkg.sv @@
// Shared types and constants for the symbol floor lookup block.
// Used by the interfaces, the register port, the controller and the datapath.
package sfl_pkg;

    localparam int W_MODE   = 1;
    localparam int W_ID     = 16;
    localparam int W_ADDR   = 64;
    localparam int W_STATUS = 2;

    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 64;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_BASE_OFFSET = 1'b0;

    localparam logic [W_MODE-1:0] MODE_INSERT = 1'b0;
    localparam logic [W_MODE-1:0] MODE_LOOKUP = 1'b1;

    localparam logic [W_STATUS-1:0] ST_HIT      = 2'd0;
    localparam logic [W_STATUS-1:0] ST_MISS     = 2'd1;
    localparam logic [W_STATUS-1:0] ST_INSERTED = 2'd2;
    localparam logic [W_STATUS-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [W_ID-1:0]   ident;
        logic [W_ADDR-1:0] addr;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SR_RD,
        S_SR_UPD,
        S_TIE_WAIT,
        S_HIT_WAIT,
        S_SH_CHK,
        S_SH_WR,
        S_PUSH
    } t_state;

    typedef enum logic [2:0] {
        PH_K,
        PH_LOW,
        PH_HIGH,
        PH_TIE,
        PH_INS
    } t_phase;

    typedef enum logic [1:0] {
        PRED_CARRY,
        PRED_GT,
        PRED_GE,
        PRED_GT_RAW
    } t_pred;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_K,
        OP_INIT_INS,
        OP_INIT_LOW,
        OP_INIT_HIGH,
        OP_INIT_TIE,
        OP_RD_MID,
        OP_UPD,
        OP_RD_FLOOR,
        OP_RD_LO,
        OP_HIT,
        OP_MISS,
        OP_FULL,
        OP_SH_START,
        OP_SH_RD,
        OP_SH_WR,
        OP_WR_NEW,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic mode_lookup;
        logic full;
        logic srch_done;
        logic found;
        logic out_free;
    } t_dp_status;

endpackage

@@ hdl/sfl_ifs.sv @@
// Valid/ready channel interfaces for the request and response streams.
// Depends on sfl_pkg for the field widths.
interface sfl_req_if;
    logic                            valid;
    logic                            ready;
    logic [sfl_pkg::W_MODE-1:0]      mode;
    logic [sfl_pkg::W_ID-1:0]        symbol_id;
    logic [sfl_pkg::W_ADDR-1:0]      address;

    modport source (output valid, output mode, output symbol_id, output address, input ready);
    modport sink   (input valid, input mode, input symbol_id, input address, output ready);
endinterface

interface sfl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sfl_pkg::W_STATUS-1:0]    status;
    logic [sfl_pkg::W_ID-1:0]        found_id;
    logic [sfl_pkg::W_ADDR-1:0]      displacement;

    modport source (output valid, output status, output found_id, output displacement,
                    input ready);
    modport sink   (input valid, input status, input found_id, input displacement,
                    output ready);
endinterface

@@ hdl/symbol_floor_lookup.sv @@
// Top level of the symbol floor lookup block: register port, controller and datapath.
// Depends on sfl_pkg, sfl_ifs, sfl_regs, sfl_ctrl, sfl_dp and the assertion macro header.
//
// Requests arrive on i_req (mode, symbol_id, address) and each gives one response on
// o_rsp (status, found_id, displacement). One request is worked on at a time; i_req.ready
// is high only while the controller waits for a request.
// A lookup runs up to four binary searches over the table, each probe a read and then a
// bound update, through the single read port of the table memory.
// An insert runs one binary search for its place, then moves each later entry up by one,
// reading it and then writing it one slot higher. An insert into a full table answers
// with the full status without a search.
// The response sits in an output register; a new request is taken while it waits, and
// the next response waits in a staging register until o_rsp is free.
// Reset clears the entry count, the base offset and the output valid; table contents are
// not cleared and need no clearing pass.
// The user writes the base offset via the APB-style port only when idle; unenforced.
`include "symbol_floor_lookup_macros.svh"

module symbol_floor_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sfl_req_if.sink                       i_req,
    sfl_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfl_pkg::CFG_AW-1:0]    paddr,
    input  logic [sfl_pkg::CFG_DW-1:0]    pwdata,
    output logic [sfl_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);

    logic [sfl_pkg::W_ADDR-1:0] base;
    sfl_pkg::t_dp_cmd           cmd;
    sfl_pkg::t_dp_status        st;
    logic                       in_ready;

    assign i_req.ready = in_ready;

    sfl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_base  (base)
    );

    sfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    sfl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_base         (base),
        .i_mode         (i_req.mode),
        .i_symbol_id    (i_req.symbol_id),
        .i_address      (i_req.address),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_found_id     (o_rsp.found_id),
        .o_displacement (o_rsp.displacement)
    );

    `SFL_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request accepted while a previous one was in progress")
    `SFL_ASSERT_IMP(a_push_slot_free, i_clk, i_rst_n, cmd.op == sfl_pkg::OP_PUSH, st.out_free, "response pushed over an untaken response")
    `SFL_ASSERT_IMP(a_id_zero_on_nohit, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != sfl_pkg::ST_HIT), o_rsp.found_id == '0, "found_id is not zero on a response without a hit")

endmodule

@@ hdl/sfl_regs.sv @@
// APB-style configuration port holding the base offset register.
// Depends on sfl_pkg for the port widths and register index.
module sfl_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfl_pkg::CFG_AW-1:0]   paddr,
    input  logic [sfl_pkg::CFG_DW-1:0]   pwdata,
    output logic [sfl_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready,
    output logic [sfl_pkg::W_ADDR-1:0]   o_base
);

    logic [sfl_pkg::W_ADDR-1:0]    r_base;
    logic [sfl_pkg::W_ADDR-1:0]    n_base;
    logic [sfl_pkg::REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[sfl_pkg::CFG_AW-1:3];
    assign pready  = 1'b1;
    assign o_base  = r_base;

    always_comb begin
        n_base = r_base;
        if (psel && penable && pwrite && (reg_idx == sfl_pkg::REG_BASE_OFFSET)) begin
            n_base = pwdata;
        end
        prdata = '0;
        if (reg_idx == sfl_pkg::REG_BASE_OFFSET) begin
            prdata = r_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else begin
            r_base <= n_base;
        end
    end

endmodule

@@ hdl/sfl_ctrl.sv @@
// Controller state machine that sequences the searches, the insert shift and the result push.
// Depends on sfl_pkg for the state, phase, command and status types.
module sfl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sfl_pkg::t_dp_status   i_st,
    output sfl_pkg::t_dp_cmd      o_cmd
);

    sfl_pkg::t_state r_state;
    sfl_pkg::t_state n_state;
    sfl_pkg::t_phase r_phase;
    sfl_pkg::t_phase n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfl_pkg::S_IDLE;
            r_phase <= sfl_pkg::PH_K;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        o_cmd.op   = sfl_pkg::OP_NONE;
        o_in_ready = (r_state == sfl_pkg::S_IDLE);
        unique case (r_state)
            sfl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = sfl_pkg::OP_LOAD;
                    n_state  = sfl_pkg::S_DISPATCH;
                end
            end
            sfl_pkg::S_DISPATCH: begin
                priority if (i_st.mode_lookup) begin
                    o_cmd.op = sfl_pkg::OP_INIT_K;
                    n_phase  = sfl_pkg::PH_K;
                    n_state  = sfl_pkg::S_SR_RD;
                end else if (i_st.full) begin
                    o_cmd.op = sfl_pkg::OP_FULL;
                    n_state  = sfl_pkg::S_PUSH;
                end else begin
                    o_cmd.op = sfl_pkg::OP_INIT_INS;
                    n_phase  = sfl_pkg::PH_INS;
                    n_state  = sfl_pkg::S_SR_RD;
                end
            end
            sfl_pkg::S_SR_RD: begin
                if (!i_st.srch_done) begin
                    o_cmd.op = sfl_pkg::OP_RD_MID;
                    n_state  = sfl_pkg::S_SR_UPD;
                end else begin
                    unique case (r_phase)
                        sfl_pkg::PH_K: begin
                            o_cmd.op = sfl_pkg::OP_INIT_LOW;
                            n_phase  = sfl_pkg::PH_LOW;
                        end
                        sfl_pkg::PH_LOW: begin
                            if (i_st.found) begin
                                o_cmd.op = sfl_pkg::OP_RD_FLOOR;
                                n_state  = sfl_pkg::S_TIE_WAIT;
                            end else begin
                                o_cmd.op = sfl_pkg::OP_INIT_HIGH;
                                n_phase  = sfl_pkg::PH_HIGH;
                            end
                        end
                        sfl_pkg::PH_HIGH: begin
                            if (i_st.found) begin
                                o_cmd.op = sfl_pkg::OP_RD_FLOOR;
                                n_state  = sfl_pkg::S_TIE_WAIT;
                            end else begin
                                o_cmd.op = sfl_pkg::OP_MISS;
                                n_state  = sfl_pkg::S_PUSH;
                            end
                        end
                        sfl_pkg::PH_TIE: begin
                            o_cmd.op = sfl_pkg::OP_RD_LO;
                            n_state  = sfl_pkg::S_HIT_WAIT;
                        end
                        sfl_pkg::PH_INS: begin
                            o_cmd.op = sfl_pkg::OP_SH_START;
                            n_state  = sfl_pkg::S_SH_CHK;
                        end
                        default: begin
                            n_state = sfl_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            sfl_pkg::S_SR_UPD: begin
                o_cmd.op = sfl_pkg::OP_UPD;
                n_state  = sfl_pkg::S_SR_RD;
            end
            sfl_pkg::S_TIE_WAIT: begin
                o_cmd.op = sfl_pkg::OP_INIT_TIE;
                n_phase  = sfl_pkg::PH_TIE;
                n_state  = sfl_pkg::S_SR_RD;
            end
            sfl_pkg::S_HIT_WAIT: begin
                o_cmd.op = sfl_pkg::OP_HIT;
                n_state  = sfl_pkg::S_PUSH;
            end
            sfl_pkg::S_SH_CHK: begin
                if (i_st.srch_done) begin
                    o_cmd.op = sfl_pkg::OP_WR_NEW;
                    n_state  = sfl_pkg::S_PUSH;
                end else begin
                    o_cmd.op = sfl_pkg::OP_SH_RD;
                    n_state  = sfl_pkg::S_SH_WR;
                end
            end
            sfl_pkg::S_SH_WR: begin
                o_cmd.op = sfl_pkg::OP_SH_WR;
                n_state  = sfl_pkg::S_SH_CHK;
            end
            sfl_pkg::S_PUSH: begin
                if (i_st.out_free) begin
                    o_cmd.op = sfl_pkg::OP_PUSH;
                    n_state  = sfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/sfl_dp.sv @@
// Datapath: symbol table memory, binary search unit, shift pointer and result registers.
// Depends on sfl_pkg; driven by commands from sfl_ctrl.
module sfl_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfl_pkg::t_dp_cmd              i_cmd,
    output sfl_pkg::t_dp_status           o_st,
    input  logic [sfl_pkg::W_ADDR-1:0]    i_base,
    input  logic [sfl_pkg::W_MODE-1:0]    i_mode,
    input  logic [sfl_pkg::W_ID-1:0]      i_symbol_id,
    input  logic [sfl_pkg::W_ADDR-1:0]    i_address,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sfl_pkg::W_STATUS-1:0]  o_status,
    output logic [sfl_pkg::W_ID-1:0]      o_found_id,
    output logic [sfl_pkg::W_ADDR-1:0]    o_displacement
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    sfl_pkg::t_entry mem [TABLE_DEPTH];

    sfl_pkg::t_entry r_rd;
    logic [sfl_pkg::W_MODE-1:0]   r_mode, n_mode;
    logic [sfl_pkg::W_ID-1:0]     r_id, n_id;
    logic [sfl_pkg::W_ADDR-1:0]   r_addr, n_addr;
    logic [sfl_pkg::W_ADDR-1:0]   r_key, n_key;
    sfl_pkg::t_pred               r_pred, n_pred;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_lo, n_lo;
    logic [CW-1:0]                r_hi, n_hi;
    logic [CW-1:0]                r_k, n_k;
    logic [CW-1:0]                r_part, n_part;
    logic [sfl_pkg::W_STATUS-1:0] r_res_status, n_res_status;
    logic [sfl_pkg::W_ID-1:0]     r_res_id, n_res_id;
    logic [sfl_pkg::W_ADDR-1:0]   r_res_disp, n_res_disp;
    logic                         r_ovalid, n_ovalid;
    logic [sfl_pkg::W_STATUS-1:0] r_o_status, n_o_status;
    logic [sfl_pkg::W_ID-1:0]     r_o_id, n_o_id;
    logic [sfl_pkg::W_ADDR-1:0]   r_o_disp, n_o_disp;

    logic [CW:0]               mid_sum;
    logic [CW-1:0]             mid;
    logic [CW-1:0]             lo_m1;
    logic [CW-1:0]             hi_m1;
    logic [sfl_pkg::W_ADDR:0]  rebased;
    logic                      pred_true;
    logic                      rd_en;
    logic [IW-1:0]             rd_idx;
    logic                      wr_en;
    logic [IW-1:0]             wr_idx;
    sfl_pkg::t_entry           wr_data;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign lo_m1   = r_lo - CW'(1);
    assign hi_m1   = r_hi - CW'(1);
    assign rebased = {1'b0, r_rd.addr} + {1'b0, i_base};

    always_comb begin
        unique case (r_pred)
            sfl_pkg::PRED_CARRY:  pred_true = rebased[sfl_pkg::W_ADDR];
            sfl_pkg::PRED_GT:     pred_true = rebased[sfl_pkg::W_ADDR-1:0] > r_key;
            sfl_pkg::PRED_GE:     pred_true = rebased[sfl_pkg::W_ADDR-1:0] >= r_key;
            sfl_pkg::PRED_GT_RAW: pred_true = r_rd.addr > r_key;
        endcase
    end

    assign o_st.mode_lookup = (r_mode == sfl_pkg::MODE_LOOKUP);
    assign o_st.full        = (r_count == CW'(TABLE_DEPTH));
    assign o_st.srch_done   = (r_lo == r_hi);
    assign o_st.found       = (r_lo != r_part);
    assign o_st.out_free    = !r_ovalid || i_ready;

    assign o_valid        = r_ovalid;
    assign o_status       = r_o_status;
    assign o_found_id     = r_o_id;
    assign o_displacement = r_o_disp;

    always_comb begin
        n_mode       = r_mode;
        n_id         = r_id;
        n_addr       = r_addr;
        n_key        = r_key;
        n_pred       = r_pred;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_k          = r_k;
        n_part       = r_part;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_disp   = r_res_disp;
        n_o_status   = r_o_status;
        n_o_id       = r_o_id;
        n_o_disp     = r_o_disp;
        n_ovalid     = r_ovalid && !i_ready;
        rd_en        = 1'b0;
        rd_idx       = mid[IW-1:0];
        wr_en        = 1'b0;
        wr_idx       = r_lo[IW-1:0];
        wr_data      = r_rd;
        unique case (i_cmd.op)
            sfl_pkg::OP_NONE: begin
            end
            sfl_pkg::OP_LOAD: begin
                n_mode = i_mode;
                n_id   = i_symbol_id;
                n_addr = i_address;
            end
            sfl_pkg::OP_INIT_K: begin
                n_lo   = '0;
                n_hi   = r_count;
                n_pred = sfl_pkg::PRED_CARRY;
            end
            sfl_pkg::OP_INIT_INS: begin
                n_lo   = '0;
                n_hi   = r_count;
                n_key  = r_addr;
                n_pred = sfl_pkg::PRED_GT_RAW;
            end
            sfl_pkg::OP_INIT_LOW: begin
                n_k    = r_lo;
                n_lo   = '0;
                n_hi   = r_lo;
                n_part = '0;
                n_key  = r_addr;
                n_pred = sfl_pkg::PRED_GT;
            end
            sfl_pkg::OP_INIT_HIGH: begin
                n_lo   = r_k;
                n_hi   = r_count;
                n_part = r_k;
                n_key  = r_addr;
                n_pred = sfl_pkg::PRED_GT;
            end
            sfl_pkg::OP_INIT_TIE: begin
                n_lo   = r_part;
                n_hi   = lo_m1;
                n_key  = rebased[sfl_pkg::W_ADDR-1:0];
                n_pred = sfl_pkg::PRED_GE;
            end
            sfl_pkg::OP_RD_MID: begin
                rd_en  = 1'b1;
                rd_idx = mid[IW-1:0];
            end
            sfl_pkg::OP_UPD: begin
                if (pred_true) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + CW'(1);
                end
            end
            sfl_pkg::OP_RD_FLOOR: begin
                rd_en  = 1'b1;
                rd_idx = lo_m1[IW-1:0];
            end
            sfl_pkg::OP_RD_LO: begin
                rd_en  = 1'b1;
                rd_idx = r_lo[IW-1:0];
            end
            sfl_pkg::OP_HIT: begin
                n_res_status = sfl_pkg::ST_HIT;
                n_res_id     = r_rd.ident;
                n_res_disp   = r_addr - r_key;
            end
            sfl_pkg::OP_MISS: begin
                n_res_status = sfl_pkg::ST_MISS;
                n_res_id     = '0;
                n_res_disp   = '0;
            end
            sfl_pkg::OP_FULL: begin
                n_res_status = sfl_pkg::ST_FULL;
                n_res_id     = '0;
                n_res_disp   = '0;
            end
            sfl_pkg::OP_SH_START: begin
                n_hi = r_count;
            end
            sfl_pkg::OP_SH_RD: begin
                rd_en  = 1'b1;
                rd_idx = hi_m1[IW-1:0];
            end
            sfl_pkg::OP_SH_WR: begin
                wr_en   = 1'b1;
                wr_idx  = r_hi[IW-1:0];
                wr_data = r_rd;
                n_hi    = hi_m1;
            end
            sfl_pkg::OP_WR_NEW: begin
                wr_en         = 1'b1;
                wr_idx        = r_lo[IW-1:0];
                wr_data.ident = r_id;
                wr_data.addr  = r_addr;
                n_count       = r_count + CW'(1);
                n_res_status  = sfl_pkg::ST_INSERTED;
                n_res_id      = '0;
                n_res_disp    = '0;
            end
            sfl_pkg::OP_PUSH: begin
                n_ovalid   = 1'b1;
                n_o_status = r_res_status;
                n_o_id     = r_res_id;
                n_o_disp   = r_res_disp;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_addr       <= n_addr;
        r_key        <= n_key;
        r_pred       <= n_pred;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_k          <= n_k;
        r_part       <= n_part;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_disp   <= n_res_disp;
        r_o_status   <= n_o_status;
        r_o_id       <= n_o_id;
        r_o_disp     <= n_o_disp;
    end

endmodule
